// ----- hdl/b31hx_pkg.sv -----
// Shared types and constants for the base-31 hash / hex digest expander.
// Used by the controller, the datapath and the top level.
package b31hx_pkg;

    localparam int HASH_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int NIB_W          = 4;
    localparam int IDX_W          = 6;
    localparam int DIGITS         = 10;
    localparam int BCD_W          = DIGITS * NIB_W;
    localparam int CONV_STEPS     = HASH_W;
    localparam int STEP_W         = $clog2(CONV_STEPS);
    localparam int DIGIT_IDX_W    = $clog2(DIGITS);
    localparam int DIGEST_LEN_DEF = 64;
    localparam int HASH_SHIFT     = 5;        // x*31 = (x << 5) - x
    localparam logic [7:0] ASCII_ZERO = 8'd48;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic fold;       // fold data_byte into the hash
        logic start;      // capture seed of running sum, clear step count
        logic conv_step;  // one binary-to-BCD shift
        logic prep;       // load digit pointer
        logic emit_step;  // produce one nibble
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic emit_last;
        logic out_free;
    } stat_t;

endpackage

// ----- hdl/b31hx_ctrl.sv -----
// Controller FSM for the base-31 hash expander: accept, convert, emit.
// Depends on b31hx_pkg.
module b31hx_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               end_only,
    input  logic               last_item,
    output logic               in_ready,
    input  b31hx_pkg::stat_t   stat,
    output b31hx_pkg::cmd_t    cmd
);

    b31hx_pkg::state_t state_reg;
    b31hx_pkg::state_t state_next;
    logic              accept;

    assign in_ready = (state_reg == b31hx_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            b31hx_pkg::ST_IDLE:
            begin
                cmd.fold  = accept && !end_only;
                cmd.start = accept && last_item;
                if (accept && last_item)
                begin
                    state_next = b31hx_pkg::ST_CONV;
                end
            end
            b31hx_pkg::ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (stat.conv_last)
                begin
                    state_next = b31hx_pkg::ST_PREP;
                end
            end
            b31hx_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = b31hx_pkg::ST_EMIT;
            end
            b31hx_pkg::ST_EMIT:
            begin
                cmd.emit_step = stat.out_free;
                if (stat.out_free && stat.emit_last)
                begin
                    state_next = b31hx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = b31hx_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b31hx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/b31hx_dp.sv -----
// Datapath: hash accumulator, shift-add-3 decimal converter, nibble generator
// and output register. Depends on b31hx_pkg.
module b31hx_dp
#(
    parameter int DIGEST_LEN = b31hx_pkg::DIGEST_LEN_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [b31hx_pkg::BYTE_W-1:0]    data_byte,
    input  b31hx_pkg::cmd_t                 cmd,
    output b31hx_pkg::stat_t                stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [b31hx_pkg::NIB_W-1:0]     hex_nibble,
    output logic [b31hx_pkg::IDX_W-1:0]     nibble_index,
    output logic                            last_nibble
);

    localparam int NW = b31hx_pkg::NIB_W;
    localparam int DW = b31hx_pkg::DIGIT_IDX_W;
    localparam logic [b31hx_pkg::IDX_W-1:0] LAST_IDX = b31hx_pkg::IDX_W'(DIGEST_LEN - 1);

    logic [b31hx_pkg::HASH_W-1:0] acc_reg, acc_next;
    logic [b31hx_pkg::BCD_W-1:0]  bcd_reg, bcd_next, bcd_adj;
    logic [b31hx_pkg::STEP_W-1:0] step_reg, step_next;
    logic [NW-1:0]                sum_reg, sum_next, sum_new;
    logic [b31hx_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [DW-1:0]                ptr_reg, ptr_next;
    logic [DW-1:0]                top_reg, top_next;
    logic [DW-1:0]                top_calc;
    logic [NW-1:0]                digit;
    logic                         out_valid_reg, out_valid_next;
    logic [NW-1:0]                nib_reg;
    logic [b31hx_pkg::IDX_W-1:0]  nidx_reg;
    logic                         nlast_reg;
    logic [b31hx_pkg::HASH_W-1:0] byte_ext;
    logic [b31hx_pkg::HASH_W-1:0] acc_fold;

    // signed-char extension, then acc*31 + byte
    assign byte_ext = {{(b31hx_pkg::HASH_W - b31hx_pkg::BYTE_W){data_byte[b31hx_pkg::BYTE_W-1]}},
                       data_byte};
    assign acc_fold = (acc_reg << b31hx_pkg::HASH_SHIFT) - acc_reg + byte_ext;

    // shift-add-3: every BCD digit >= 5 gets +3 before the shift
    always_comb
    begin
        for (int d = 0; d < b31hx_pkg::DIGITS; d++)
        begin
            if (bcd_reg[d*NW +: NW] >= NW'(5))
            begin
                bcd_adj[d*NW +: NW] = bcd_reg[d*NW +: NW] + NW'(3);
            end
            else
            begin
                bcd_adj[d*NW +: NW] = bcd_reg[d*NW +: NW];
            end
        end
    end

    // position of the most significant nonzero digit (units when all zero)
    always_comb
    begin
        top_calc = '0;
        for (int d = 0; d < b31hx_pkg::DIGITS; d++)
        begin
            if (bcd_reg[d*NW +: NW] != '0)
            begin
                top_calc = DW'(d);
            end
        end
    end

    assign digit   = bcd_reg[ptr_reg*NW +: NW];
    assign sum_new = sum_reg + digit + b31hx_pkg::ASCII_ZERO[NW-1:0] + idx_reg[NW-1:0];

    assign stat.conv_last = (step_reg == b31hx_pkg::STEP_W'(b31hx_pkg::CONV_STEPS - 1));
    assign stat.emit_last = (idx_reg == LAST_IDX);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        acc_next       = acc_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.fold)
        begin
            acc_next = acc_fold;
        end
        if (cmd.start)
        begin
            step_next = '0;
            bcd_next  = '0;
            sum_next  = cmd.fold ? acc_fold[NW-1:0] : acc_reg[NW-1:0];
        end
        if (cmd.conv_step)
        begin
            // accumulator shifts out MSB first and is zero after the last step
            bcd_next  = {bcd_adj[b31hx_pkg::BCD_W-2:0], acc_reg[b31hx_pkg::HASH_W-1]};
            acc_next  = acc_reg << 1;
            step_next = step_reg + 1'b1;
        end
        if (cmd.prep)
        begin
            ptr_next = top_calc;
            top_next = top_calc;
            idx_next = '0;
        end
        if (cmd.emit_step)
        begin
            sum_next       = sum_new;
            idx_next       = idx_reg + 1'b1;
            ptr_next       = (ptr_reg == '0) ? top_reg : ptr_reg - 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            step_reg      <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        if (cmd.emit_step)
        begin
            nib_reg   <= sum_new;
            nidx_reg  <= idx_reg;
            nlast_reg <= (idx_reg == LAST_IDX);
        end
    end

    assign out_valid    = out_valid_reg;
    assign hex_nibble   = nib_reg;
    assign nibble_index = nidx_reg;
    assign last_nibble  = nlast_reg;

endmodule

// ----- hdl/base31_hash_hex_expander.sv -----
// Bytes: one per cycle while idle. Last item: decimal conversion (one shift-add-3
// step per cycle), then a setup state, then DIGEST_LEN nibbles at one per cycle,
// while out_ready allows, through the output register.
// Input is held off from the last item until the final nibble is registered.
// rst_n (async, active low) clears hash, counters and FSM; digits are not reset.
module base31_hash_hex_expander
#(
    parameter int DIGEST_LEN = b31hx_pkg::DIGEST_LEN_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [b31hx_pkg::BYTE_W-1:0]    data_byte,
    input  logic                            end_only,
    input  logic                            last_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [b31hx_pkg::NIB_W-1:0]     hex_nibble,
    output logic [b31hx_pkg::IDX_W-1:0]     nibble_index,
    output logic                            last_nibble
);

    b31hx_pkg::cmd_t  cmd;
    b31hx_pkg::stat_t stat;

    b31hx_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .end_only  (end_only),
        .last_item (last_item),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    b31hx_dp #(.DIGEST_LEN(DIGEST_LEN)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hex_nibble   (hex_nibble),
        .nibble_index (nibble_index),
        .last_nibble  (last_nibble)
    );

endmodule

// ----- hdl/b31hx_checker.sv -----
// Port-level checks for base31_hash_hex_expander, bound to the top level.
// Depends on b31hx_pkg.
module b31hx_checker
#(
    parameter int DIGEST_LEN = b31hx_pkg::DIGEST_LEN_DEF
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         last_item,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [b31hx_pkg::NIB_W-1:0]  hex_nibble,
    input logic [b31hx_pkg::IDX_W-1:0]  nibble_index,
    input logic                         last_nibble
);

    localparam logic [b31hx_pkg::IDX_W-1:0] LAST_IDX = b31hx_pkg::IDX_W'(DIGEST_LEN - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hex_nibble) && $stable(nibble_index))
        else $error("output beat changed while stalled");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_nibble == (nibble_index == LAST_IDX)))
        else $error("last_nibble does not match final index");

    a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_nibble |-> !in_ready)
        else $error("input taken in the middle of a digest burst");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_item |=> !in_ready)
        else $error("input still open after last item");

endmodule

bind base31_hash_hex_expander b31hx_checker #(.DIGEST_LEN(DIGEST_LEN)) u_b31hx_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hex_nibble   (hex_nibble),
    .nibble_index (nibble_index),
    .last_nibble  (last_nibble)
);
